// ===== design/tcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsc_pkg: shared types, constants and calendar helpers
// Register map, queue entry, back-end sequencer states and the small
// Gregorian calendar functions used by both the front and the back end.
// ----------------------------------------------------------------------------
package tcsc_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [13:0] MAX_YEAR    = 14'd9999;
	localparam logic [16:0] MAX_SOD     = 17'd86399;
	localparam logic [10:0] MAX_MOD     = 11'd1439;
	localparam logic [13:0] RESET_MIN_YEAR = 14'd2024;

	// floor(key / 10000) as (key * RECIP_10K) >> 44, exact for 27-bit keys
	localparam logic [30:0] RECIP_10K   = 31'd1759218605;
	// floor(r / 100) as (r * RECIP_100) >> 19, exact for r < 10000
	localparam logic [12:0] RECIP_100   = 13'd5243;
	// floor(y / 400) as (y * RECIP_400) >> 22, exact for 14-bit y
	localparam logic [13:0] RECIP_400   = 14'd10486;
	// days from 0000-03-01 (shifted one era) back to 1970-01-01
	localparam logic [23:0] EPOCH_OFFS  = 24'd865565;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_YEAR    = 3'd0,
		REG_FIRST_DAY   = 3'd1,
		REG_HIST_MAX    = 3'd2,
		REG_TARGET_DATE = 3'd3,
		REG_TARGET_SOD  = 3'd4,
		REG_WIN_START   = 3'd5,
		REG_WIN_END     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [13:0] min_trusted_year;
		logic [26:0] first_day_key;
		logic [31:0] historical_max_days;
		logic [26:0] target_date_key;
		logic [16:0] target_second_of_day;
		logic [10:0] window_start_minute;
		logic [10:0] window_end_minute;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic        ok;
		logic [26:0] key;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [16:0] sod;
		logic [10:0] mod;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SPLIT_HI,
		BK_SPLIT_LO,
		BK_SPLIT_MD,
		BK_PREP,
		BK_DAYS,
		BK_WALL,
		BK_DONE
	} bk_state_t;

	// y%4==0 and (y%100!=0 or y%400==0), via y%25 and low bits
	function automatic logic is_leap(input logic [13:0] y);
		logic [28:0] prod;
		logic [13:0] q25;
		logic [13:0] r25;
		prod = 29'(y) * 29'd20972;
		q25  = 14'(prod >> 19);
		r25  = y - 14'(q25 * 14'd25);
		return (y[1:0] == 2'b00) && ((r25 != 14'd0) || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [13:0] y, input logic [3:0] m);
		logic [4:0] len;
		case (m) inside
			4'd2:                                    len = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default:                                 len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic date_ok(input logic [13:0] y, input logic [6:0] m,
			input logic [6:0] d, input logic [13:0] min_year);
		return (y >= min_year) && (y <= MAX_YEAR) && (m >= 7'd1) && (m <= 7'd12) &&
			(d != 7'd0) && (d <= 7'(month_len(y, m[3:0])));
	endfunction

	// day of year counted from 1 March: (153*mp+2)/5
	function automatic logic [8:0] doy_base(input logic [3:0] m);
		logic [8:0] b;
		case (m)
			4'd3:    b = 9'd0;
			4'd4:    b = 9'd31;
			4'd5:    b = 9'd61;
			4'd6:    b = 9'd92;
			4'd7:    b = 9'd122;
			4'd8:    b = 9'd153;
			4'd9:    b = 9'd184;
			4'd10:   b = 9'd214;
			4'd11:   b = 9'd245;
			4'd12:   b = 9'd275;
			4'd1:    b = 9'd306;
			4'd2:    b = 9'd337;
			default: b = 9'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== design/tcsc_front.sv =====
// ----------------------------------------------------------------------------
// tcsc_front: sample intake and classification
// Registers one request, checks it against the calendar and trusted year,
// and forms the date key, second of day and minute of day for the queue.
// ----------------------------------------------------------------------------
module tcsc_front import tcsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [13:0] min_trusted_year,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        time_set,
	input  logic [13:0] local_year,
	input  logic [3:0]  local_month,
	input  logic [4:0]  local_day,
	input  logic [4:0]  local_hour,
	input  logic [5:0]  local_minute,
	input  logic [5:0]  local_second,
	input  logic        q_full,
	output logic        q_push,
	output entry_t      q_entry
);

	logic        vld_s1;
	logic        set_s1;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [5:0]  second_s1;
	logic        take;
	logic        ok;

	assign q_push   = vld_s1 && !q_full;
	assign in_stall = vld_s1 && q_full;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			set_s1    <= time_set;
			year_s1   <= local_year;
			month_s1  <= local_month;
			day_s1    <= local_day;
			hour_s1   <= local_hour;
			minute_s1 <= local_minute;
			second_s1 <= local_second;
		end
	end

	assign ok = set_s1 && date_ok(year_s1, 7'(month_s1), 7'(day_s1), min_trusted_year) &&
		(hour_s1 <= 5'd23) && (minute_s1 <= 6'd59) && (second_s1 <= 6'd59);

	always_comb begin
		q_entry.ok    = ok;
		q_entry.key   = ok ? (27'(year_s1) * 27'd10000 + 27'(month_s1) * 27'd100 +
			27'(day_s1)) : 27'd0;
		q_entry.year  = year_s1;
		q_entry.month = month_s1;
		q_entry.day   = day_s1;
		q_entry.sod   = 17'(hour_s1) * 17'd3600 + 17'(minute_s1) * 17'd60 + 17'(second_s1);
		q_entry.mod   = 11'(hour_s1) * 11'd60 + 11'(minute_s1);
	end

endmodule

// ===== design/tcsc_fifo.sv =====
// ----------------------------------------------------------------------------
// tcsc_fifo: request queue between front and back end
// Small circular buffer of classified samples.
// ----------------------------------------------------------------------------
module tcsc_fifo import tcsc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	output logic   full,
	input  logic   pop,
	output entry_t dout,
	output logic   empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t        mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

endmodule

// ===== design/tcsc_back.sv =====
// ----------------------------------------------------------------------------
// tcsc_back: date arithmetic sequencer and result register
// Splits the configured date keys, converts three dates to days since 1970,
// forms wall seconds, updates rollback state and loads the result.
// ----------------------------------------------------------------------------
module tcsc_back import tcsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  entry_t      q_entry,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sample_valid,
	output logic [26:0] day_key,
	output logic [31:0] rollback_total,
	output logic        target_reached,
	output logic [31:0] companion_days,
	output logic        in_daily_window
);

	localparam int unsigned DS = 0;
	localparam int unsigned DT = 1;
	localparam int unsigned DF = 2;

	bk_state_t st_q, st_nxt;
	entry_t    item_q;

	logic [13:0] thi_q, fhi_q, trem_q, frem_q;
	logic [6:0]  tmm_q, fmm_q, tdd_q, fdd_q;
	logic        tgt_ok_q, first_ok_q;
	logic [4:0]  era_q [3];
	logic [8:0]  yoe_q [3];
	logic [8:0]  base_q [3];
	logic signed [23:0] days_q [3];
	logic signed [39:0] wall_s_q, wall_t_q;
	logic signed [24:0] elapsed_q;

	logic               has_prev_q;
	logic signed [39:0] prev_wall_q;
	logic [31:0]        cnt_q;

	logic        out_free;
	logic        load;
	logic [13:0] py [3];
	logic [3:0]  pm [3];
	logic [4:0]  pd [3];
	logic [6:0]  tdd_c, fdd_c;
	logic        bump;
	logic [31:0] cnt_nxt;
	logic [31:0] comp_c;
	logic        win_c;

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			BK_IDLE:     if (!q_empty) st_nxt = BK_SPLIT_HI;
			BK_SPLIT_HI: st_nxt = BK_SPLIT_LO;
			BK_SPLIT_LO: st_nxt = BK_SPLIT_MD;
			BK_SPLIT_MD: st_nxt = BK_PREP;
			BK_PREP:     st_nxt = BK_DAYS;
			BK_DAYS:     st_nxt = BK_WALL;
			BK_WALL:     st_nxt = BK_DONE;
			BK_DONE:     if (out_free) st_nxt = BK_IDLE;
			default:     st_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load  = 1'b0;
		unique case (st_q)
			BK_IDLE: q_pop = !q_empty;
			BK_DONE: load  = out_free;
			default: ;
		endcase
	end

	// date operands per converter lane
	always_comb begin
		py[DS] = item_q.year;
		pm[DS] = item_q.month;
		pd[DS] = item_q.day;
		py[DT] = thi_q;
		pm[DT] = tmm_q[3:0];
		pd[DT] = tdd_q[4:0];
		py[DF] = fhi_q;
		pm[DF] = fmm_q[3:0];
		pd[DF] = fdd_q[4:0];
		tdd_c  = 7'(trem_q - 14'(tmm_q) * 14'd100);
		fdd_c  = 7'(frem_q - 14'(fmm_q) * 14'd100);
	end

	always_comb begin
		bump    = item_q.ok && has_prev_q && (wall_s_q < prev_wall_q) && (cnt_q != '1);
		cnt_nxt = bump ? cnt_q + 32'd1 : cnt_q;
		comp_c  = cfg.historical_max_days;
		if (item_q.ok && first_ok_q && !elapsed_q[24] &&
				(32'(elapsed_q) + 32'd1 > cfg.historical_max_days)) begin
			comp_c = 32'(elapsed_q) + 32'd1;
		end
		win_c = 1'b0;
		if (item_q.ok && (cfg.window_start_minute <= MAX_MOD) &&
				(cfg.window_end_minute <= MAX_MOD) &&
				(cfg.window_start_minute != cfg.window_end_minute)) begin
			if (cfg.window_start_minute < cfg.window_end_minute) begin
				win_c = (item_q.mod >= cfg.window_start_minute) &&
					(item_q.mod < cfg.window_end_minute);
			end else begin
				win_c = (item_q.mod >= cfg.window_start_minute) ||
					(item_q.mod < cfg.window_end_minute);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			out_valid   <= 1'b0;
			has_prev_q  <= 1'b0;
			prev_wall_q <= '0;
			cnt_q       <= '0;
		end else begin
			st_q <= st_nxt;
			if (load) begin
				out_valid <= 1'b1;
				cnt_q     <= cnt_nxt;
				if (item_q.ok) begin
					has_prev_q  <= 1'b1;
					prev_wall_q <= wall_s_q;
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				item_q <= q_entry;
			end
			BK_SPLIT_HI: begin
				thi_q <= 14'((58'(cfg.target_date_key) * 58'(RECIP_10K)) >> 44);
				fhi_q <= 14'((58'(cfg.first_day_key) * 58'(RECIP_10K)) >> 44);
			end
			BK_SPLIT_LO: begin
				trem_q <= 14'(cfg.target_date_key - 27'(thi_q) * 27'd10000);
				frem_q <= 14'(cfg.first_day_key - 27'(fhi_q) * 27'd10000);
			end
			BK_SPLIT_MD: begin
				tmm_q <= 7'((27'(trem_q) * 27'(RECIP_100)) >> 19);
				fmm_q <= 7'((27'(frem_q) * 27'(RECIP_100)) >> 19);
			end
			BK_PREP: begin
				tdd_q    <= tdd_c;
				fdd_q    <= fdd_c;
				tgt_ok_q <= (cfg.target_date_key != '0) &&
					(cfg.target_second_of_day <= MAX_SOD) &&
					date_ok(thi_q, tmm_q, tdd_c, cfg.min_trusted_year);
				first_ok_q <= (cfg.first_day_key != '0) &&
					date_ok(fhi_q, fmm_q, fdd_c, cfg.min_trusted_year);
				for (int i = 0; i < 3; i++) begin
					logic [13:0] yy;
					logic [4:0]  era;
					// one era of offset keeps January of year 0 positive
					yy       = py[i] + 14'd400 - 14'(pm[i] <= 4'd2);
					era      = 5'((28'(yy) * 28'(RECIP_400)) >> 22);
					era_q[i]  <= era;
					yoe_q[i]  <= 9'(yy - 14'(era) * 14'd400);
					base_q[i] <= doy_base(pm[i]);
				end
			end
			BK_DAYS: begin
				for (int i = 0; i < 3; i++) begin
					logic [23:0] pos;
					logic [23:0] neg;
					logic [8:0]  d;
					d   = (i == DS) ? 9'(pd[i]) : ((i == DT) ? 9'(tdd_q) : 9'(fdd_q));
					pos = 24'(era_q[i]) * 24'd146097 + 24'(yoe_q[i]) * 24'd365 +
						24'(yoe_q[i] >> 2) + 24'(base_q[i]) + 24'(d);
					neg = 24'((15'(yoe_q[i]) * 15'd41) >> 12) + 24'd1 + EPOCH_OFFS;
					days_q[i] <= $signed(pos - neg);
				end
			end
			BK_WALL: begin
				wall_s_q  <= 40'(days_q[DS]) * 40'sd86400 + $signed({23'd0, item_q.sod});
				wall_t_q  <= 40'(days_q[DT]) * 40'sd86400 +
					$signed({23'd0, cfg.target_second_of_day});
				elapsed_q <= 25'(days_q[DS]) - 25'(days_q[DF]);
			end
			BK_DONE: begin
				if (load) begin
					sample_valid    <= item_q.ok;
					day_key         <= item_q.key;
					rollback_total  <= cnt_nxt;
					target_reached  <= item_q.ok && tgt_ok_q && (wall_s_q >= wall_t_q);
					companion_days  <= comp_c;
					in_daily_window <= win_c;
				end
			end
			default: ;
		endcase
	end

	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= $past(cnt_q))
		else $error("rollback count went down");

	a_prev_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(has_prev_q))
		else $error("previous-sample flag cleared");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_DONE && !out_free) |=> (st_q == BK_DONE))
		else $error("result dropped while output register busy");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q == BK_SPLIT_HI))
		else $error("request popped outside idle");

endmodule

// ===== design/trusted_clock_sample_checker.sv =====
// ----------------------------------------------------------------------------
// trusted_clock_sample_checker: wall-clock sample validation
// Validates date-time samples, tracks clock rollbacks and reports the date
// key, target reached, companion day count and daily window hit.
// ----------------------------------------------------------------------------
// Each request is held in the intake register, waits in a short queue
// and is then worked by the back-end sequencer (key split, day
// conversion, wall seconds, result load), which finishes one sample
// before it pops the next and so sets the sustained rate. A finished result
// sits in the output register while the next request is already being
// worked. Configuration is written through cfg_we/cfg_index/cfg_wdata and
// must only change while no request is in flight.
module trusted_clock_sample_checker import tcsc_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  time_set,
	input  logic [13:0]           local_year,
	input  logic [3:0]            local_month,
	input  logic [4:0]            local_day,
	input  logic [4:0]            local_hour,
	input  logic [5:0]            local_minute,
	input  logic [5:0]            local_second,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  sample_valid,
	output logic [26:0]           day_key,
	output logic [31:0]           rollback_total,
	output logic                  target_reached,
	output logic [31:0]           companion_days,
	output logic                  in_daily_window
);

	cfg_t   cfg_q;
	logic   q_full, q_push, q_pop, q_empty;
	entry_t push_entry, pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_trusted_year     <= RESET_MIN_YEAR;
			cfg_q.first_day_key        <= '0;
			cfg_q.historical_max_days  <= '0;
			cfg_q.target_date_key      <= '0;
			cfg_q.target_second_of_day <= '0;
			cfg_q.window_start_minute  <= '0;
			cfg_q.window_end_minute    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_YEAR:    cfg_q.min_trusted_year     <= cfg_wdata[13:0];
				REG_FIRST_DAY:   cfg_q.first_day_key        <= cfg_wdata[26:0];
				REG_HIST_MAX:    cfg_q.historical_max_days  <= cfg_wdata[31:0];
				REG_TARGET_DATE: cfg_q.target_date_key      <= cfg_wdata[26:0];
				REG_TARGET_SOD:  cfg_q.target_second_of_day <= cfg_wdata[16:0];
				REG_WIN_START:   cfg_q.window_start_minute  <= cfg_wdata[10:0];
				REG_WIN_END:     cfg_q.window_end_minute    <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	tcsc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.min_trusted_year (cfg_q.min_trusted_year),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.time_set         (time_set),
		.local_year       (local_year),
		.local_month      (local_month),
		.local_day        (local_day),
		.local_hour       (local_hour),
		.local_minute     (local_minute),
		.local_second     (local_second),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_entry          (push_entry)
	);

	tcsc_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_entry),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (pop_entry),
		.empty  (q_empty)
	);

	tcsc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_entry         (pop_entry),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sample_valid    (sample_valid),
		.day_key         (day_key),
		.rollback_total  (rollback_total),
		.target_reached  (target_reached),
		.companion_days  (companion_days),
		.in_daily_window (in_daily_window)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: trusted clock sample checker testbench
// Drives date-time samples with random gaps, predicts each result from a
// behavioural calendar model and checks every output field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import tcsc_pkg::*;

	typedef struct packed {
		logic        sv;
		logic [26:0] key;
		logic [31:0] rb;
		logic        reached;
		logic [31:0] comp;
		logic        win;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic time_set = 1'b0;
	logic [13:0] local_year = '0;
	logic [3:0] local_month = '0;
	logic [4:0] local_day = '0;
	logic [4:0] local_hour = '0;
	logic [5:0] local_minute = '0;
	logic [5:0] local_second = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic sample_valid;
	logic [26:0] day_key;
	logic [31:0] rollback_total;
	logic target_reached;
	logic [31:0] companion_days;
	logic in_daily_window;

	trusted_clock_sample_checker uut (.*);

	always #2 clk = ~clk;

	// predictor copies of configuration and state
	logic [13:0] m_min_year;
	logic [26:0] m_first_day, m_target_date;
	logic [31:0] m_hist_max;
	logic [16:0] m_target_sod;
	logic [10:0] m_win_start, m_win_end;
	bit m_has_prev;
	longint m_prev_wall;
	logic [31:0] m_rollbacks;

	verdict_t expected_q[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stall_on = 1'b1;

	function automatic int days_in_month(int y, int m);
		bit leap;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		case (m)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic bit trusted_date(int y, int m, int d);
		return y >= m_min_year && y <= 9999 && m >= 1 && m <= 12 && d >= 1 &&
			d <= days_in_month(y, m);
	endfunction

	// days since 1970-01-01, years 0..9999
	function automatic longint epoch_days(int year, int month, int day);
		longint y, era, yoe, mp, doy;
		y = year - (month <= 2 ? 1 : 0);
		era = (y >= 0 ? y : y - 399) / 400;
		yoe = y - era * 400;
		mp = month > 2 ? month - 3 : month + 9;
		doy = (153 * mp + 2) / 5 + day - 1;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
	endfunction

	function automatic bit split_key(int key, output int y, output int m, output int d);
		y = key / 10000;
		m = (key / 100) % 100;
		d = key % 100;
		return key != 0 && trusted_date(y, m, d);
	endfunction

	function automatic verdict_t predict_sample(bit ts, int y, int mo, int d, int h, int mi,
			int s);
		verdict_t v;
		longint days, wall, el;
		int ty, tm, td, fy, fm, fd, cur;
		v = '0;
		v.comp = m_hist_max;
		v.sv = ts && trusted_date(y, mo, d) && h <= 23 && mi <= 59 && s <= 59;
		if (v.sv) begin
			days = epoch_days(y, mo, d);
			wall = days * 86400 + h * 3600 + mi * 60 + s;
			if (m_has_prev && wall < m_prev_wall && m_rollbacks != 32'hFFFF_FFFF)
				m_rollbacks++;
			m_has_prev = 1'b1;
			m_prev_wall = wall;
			v.key = 27'(y * 10000 + mo * 100 + d);
			if (m_target_sod <= 86399 && split_key(m_target_date, ty, tm, td))
				v.reached = wall >= epoch_days(ty, tm, td) * 86400 + longint'(m_target_sod);
			if (split_key(m_first_day, fy, fm, fd)) begin
				el = days - epoch_days(fy, fm, fd);
				if (el >= 0 && el + 1 > m_hist_max)
					v.comp = el + 1 > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(el + 1);
			end
			if (m_win_start <= 1439 && m_win_end <= 1439 && m_win_start != m_win_end) begin
				cur = h * 60 + mi;
				if (m_win_start < m_win_end)
					v.win = cur >= m_win_start && cur < m_win_end;
				else
					v.win = cur >= m_win_start || cur < m_win_end;
			end
		end
		v.rb = m_rollbacks;
		return v;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 50) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// valid stays high into the next request when there is no gap
	task automatic send_sample(bit ts, int y, int mo, int d, int h, int mi, int s);
		int g;
		g = stall_on ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		expected_q.push_back(predict_sample(ts, y, mo, d, h, mi, s));
		in_valid <= 1'b1;
		time_set <= ts;
		local_year <= 14'(y);
		local_month <= 4'(mo);
		local_day <= 5'(d);
		local_hour <= 5'(h);
		local_minute <= 6'(mi);
		local_second <= 6'(s);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_MIN_YEAR: m_min_year = val[13:0];
			REG_FIRST_DAY: m_first_day = val[26:0];
			REG_HIST_MAX: m_hist_max = val;
			REG_TARGET_DATE: m_target_date = val[26:0];
			REG_TARGET_SOD: m_target_sod = val[16:0];
			REG_WIN_START: m_win_start = val[10:0];
			default: m_win_end = val[10:0];
		endcase
	endtask

	task automatic configure(int miny, int first, logic [31:0] hist, int tgt, int tsod,
			int ws, int we);
		write_reg(REG_MIN_YEAR, miny);
		write_reg(REG_FIRST_DAY, first);
		write_reg(REG_HIST_MAX, hist);
		write_reg(REG_TARGET_DATE, tgt);
		write_reg(REG_TARGET_SOD, tsod);
		write_reg(REG_WIN_START, ws);
		write_reg(REG_WIN_END, we);
		cfg_we <= 1'b0;
	endtask

	// well-formed date-time in a chosen range of years
	task automatic send_good(int ylo, int yhi);
		int y, m;
		y = $urandom_range(ylo, yhi);
		m = $urandom_range(1, 12);
		send_sample(1'b1, y, m, $urandom_range(1, days_in_month(y, m)), $urandom_range(0, 23),
			$urandom_range(0, 59), $urandom_range(0, 59));
	endtask

	task automatic send_noise();
		send_sample($urandom_range(0, 1), $urandom_range(0, 16383), $urandom_range(0, 15),
			$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
			$urandom_range(0, 63));
	endtask

	task automatic test_directed();
		configure(0, 20240101, 0, 20240229, 43200, 1380, 60);
		send_sample(1'b1, 2024, 2, 29, 12, 0, 0);
		send_sample(1'b1, 2023, 2, 29, 0, 0, 0);
		send_sample(1'b1, 2000, 2, 29, 23, 59, 59);
		send_sample(1'b1, 1900, 2, 29, 0, 0, 0);
		send_sample(1'b0, 2024, 5, 5, 5, 5, 5);
		send_sample(1'b1, 0, 1, 1, 0, 0, 0);
		send_sample(1'b1, 9999, 12, 31, 23, 59, 59);
		send_sample(1'b1, 16383, 15, 31, 31, 63, 63);
		send_sample(1'b1, 2024, 0, 1, 0, 0, 0);
		send_sample(1'b1, 2024, 13, 1, 0, 0, 0);
		send_sample(1'b1, 2024, 4, 31, 0, 0, 0);
		send_sample(1'b1, 2024, 4, 0, 0, 0, 0);
		send_sample(1'b1, 2024, 4, 30, 24, 0, 0);
		send_sample(1'b1, 2024, 4, 30, 0, 60, 0);
		send_sample(1'b1, 2024, 4, 30, 0, 0, 60);
		send_sample(1'b1, 2024, 2, 29, 11, 59, 59);
		send_sample(1'b1, 2024, 1, 1, 0, 59, 0);
		send_sample(1'b1, 2024, 1, 1, 1, 0, 0);
		send_sample(1'b1, 1969, 12, 31, 23, 0, 0);
		drain();
	endtask

	task automatic test_config_extremes();
		configure(9999, 99991231, 32'hFFFF_FFFF, 99991231, 86399, 1439, 0);
		send_sample(1'b1, 9999, 12, 31, 23, 59, 59);
		send_sample(1'b1, 9998, 12, 31, 23, 59, 59);
		drain();
		configure(16383, 134217727, 0, 134217727, 131071, 2047, 2047);
		send_sample(1'b1, 9999, 1, 1, 0, 0, 0);
		drain();
		configure(0, 101, 5, 101, 86400, 100, 100);
		repeat (8) send_good(0, 9999);
		drain();
		configure(0, 101, 0, 99991231, 0, 0, 1439);
		send_sample(1'b1, 9999, 12, 31, 23, 59, 0);
		send_sample(1'b1, 0, 1, 1, 0, 0, 0);
		drain();
	endtask

	task automatic test_random(int n, int miny);
		configure(miny, $urandom_range(0, 1) ? 20200000 + $urandom_range(101, 1231) : 0,
			$urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3000),
			$urandom_range(0, 3) == 0 ? $urandom_range(0, 134217727)
				: 20250000 + $urandom_range(101, 1231),
			$urandom_range(0, 9) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 86399),
			$urandom_range(0, 1500), $urandom_range(0, 1500));
		repeat (n) begin
			if ($urandom_range(0, 99) < 75) send_good(miny, miny + 5);
			else if ($urandom_range(0, 1)) send_good(0, 9999);
			else send_noise();
		end
		drain();
	endtask

	task automatic test_quiet_sender();
		stall_on = 1'b0;
		repeat (40) send_good(2024, 2026);
		drain();
		stall_on = 1'b1;
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t got, exp_v;
		if (arst_n && out_valid && !out_stall) begin
			got = {sample_valid, day_key, rollback_total, target_reached, companion_days,
				in_daily_window};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				exp_v = expected_q.pop_front();
				if (got !== exp_v) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: sv %b/%b key %0d/%0d rb %0d/%0d reached %b/%b comp %0d/%0d win %b/%b",
							exp_v.sv, got.sv, exp_v.key, got.key, exp_v.rb, got.rb,
							exp_v.reached, got.reached, exp_v.comp, got.comp, exp_v.win, got.win);
				end
			end
		end
	end

	// receiver stall, bursty with quiet stretches
	always @(posedge clk) begin
		if (!stall_on) out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
		else if (out_stall) out_stall <= $urandom_range(0, 9) != 0;
		else out_stall <= $urandom_range(0, 99) < 20 && ($time / 4000) % 2 == 0;
	end

	// watchdog on accepted requests and results
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		m_min_year = 14'd2024;
		m_first_day = '0;
		m_hist_max = '0;
		m_target_date = '0;
		m_target_sod = '0;
		m_win_start = '0;
		m_win_end = '0;
		m_has_prev = 1'b0;
		m_prev_wall = 0;
		m_rollbacks = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		for (int i = 0; i < 6; i++)
			test_random(200, i == 0 ? 0 : (i == 5 ? 9990 : $urandom_range(1970, 2100)));
		test_quiet_sender();
		drain();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
